// File: design/pgtp_pkg.sv
package pgtp_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QUEUE_PTR_W       = $clog2(QUEUE_DEPTH);

    // configuration register indexes
    localparam logic CFG_PIXEL_MODE = 1'b0;
    localparam logic CFG_THRESHOLD  = 1'b1;

    // pixel modes
    localparam logic [1:0] MODE_PAL4   = 2'd0;
    localparam logic [1:0] MODE_PAL8   = 2'd1;
    localparam logic [1:0] MODE_DIRECT = 2'd2;

    localparam logic [1:0] PIXEL_MODE_RESET = MODE_PAL8;
    localparam logic [7:0] THRESHOLD_RESET  = 8'd200;

    // item kinds on tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_PAL8,
        CMD_PAL4,
        CMD_DIRECT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  addr_a;
        logic [7:0]  addr_b;
        logic        ok_a;
        logic [23:0] rgb;
    } cmd_t;

    function automatic logic [7:0] gray_of(input logic [23:0] rgb);
        logic [15:0] sum;
        sum = 16'(16'd76 * 16'(rgb[23:16])) + 16'(16'd150 * 16'(rgb[15:8]))
            + 16'(16'd30 * 16'(rgb[7:0]));
        return sum[15:8];
    endfunction

endpackage

// File: design/pgtp_front.sv
module pgtp_front #(
    parameter int PALETTE_DEPTH = pgtp_pkg::PALETTE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic          cfg_addr,
    input  logic [7:0]    cfg_wdata,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [39:0]   s_tdata,
    input  logic          s_tuser,
    input  logic          q_full,
    output logic          q_push,
    output pgtp_pkg::cmd_t q_cmd,
    output logic [7:0]    threshold
);
    import pgtp_pkg::*;

    logic [1:0] mode_reg;
    logic [7:0] threshold_reg;
    logic       keep;

    logic [7:0] entry;
    logic [7:0] code;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= PIXEL_MODE_RESET;
            threshold_reg <= THRESHOLD_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_PIXEL_MODE: mode_reg      <= cfg_wdata[1:0];
                CFG_THRESHOLD:  threshold_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign entry = s_tdata[7:0];
    assign code  = s_tdata[39:32];

    always_comb begin
        q_cmd.rgb    = s_tdata[31:8];
        q_cmd.addr_b = {4'b0, code[3:0]};
        q_cmd.addr_a = code;
        q_cmd.ok_a   = 1'b1;
        q_cmd.kind   = CMD_PAL8;
        keep         = 1'b0;
        if (s_tuser == OP_LOAD) begin
            q_cmd.kind   = CMD_WRITE;
            q_cmd.addr_a = entry;
            // writes past the palette are dropped
            keep         = ({1'b0, entry} < 9'(PALETTE_DEPTH));
        end else begin
            unique case (mode_reg)
                MODE_PAL4: begin
                    q_cmd.kind   = CMD_PAL4;
                    q_cmd.addr_a = {4'b0, code[7:4]};
                    keep         = 1'b1;
                end
                MODE_PAL8: begin
                    q_cmd.kind = CMD_PAL8;
                    q_cmd.ok_a = ({1'b0, code} < 9'(PALETTE_DEPTH));
                    keep       = 1'b1;
                end
                MODE_DIRECT: begin
                    q_cmd.kind = CMD_DIRECT;
                    keep       = 1'b1;
                end
                default: keep = 1'b0;
            endcase
        end
    end

    assign s_tready  = !q_full;
    assign q_push    = s_tvalid && s_tready && keep;
    assign threshold = threshold_reg;

endmodule

// File: design/pgtp_fifo.sv
module pgtp_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  pgtp_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output pgtp_pkg::cmd_t head_cmd
);
    import pgtp_pkg::*;

    cmd_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = QUEUE_PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop) begin
            rd_ptr_next = QUEUE_PTR_W'(rd_ptr_reg + 1'b1);
        end
        priority if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full      = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = slot_reg[rd_ptr_reg];

endmodule

// File: design/pgtp_back.sv
module pgtp_back #(
    parameter int PALETTE_DEPTH = pgtp_pkg::PALETTE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cmd_valid,
    input  pgtp_pkg::cmd_t cmd,
    output logic           cmd_pop,
    input  logic [7:0]     threshold,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata
);
    import pgtp_pkg::*;

    localparam int IDX_W = $clog2(PALETTE_DEPTH);

    logic [23:0] palette [PALETTE_DEPTH];

    logic        adv;

    // stage 1: palette access
    logic        s1_valid_reg;
    cmd_kind_t   s1_kind_reg;
    logic        s1_ok_a_reg;
    logic [23:0] s1_rgb_reg;
    logic [23:0] rd_a_reg;
    logic [23:0] rd_b_reg;

    // stage 2: gray and threshold
    logic        s2_valid_reg;
    logic        s2_two_reg;
    logic        s2_bit_a_reg;
    logic        s2_bit_b_reg;
    logic [23:0] col_a;
    logic [23:0] col_b;

    // stage 3: packing
    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  shift_reg, shift_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_data_reg, out_data_next;
    logic [7:0]  shift1, shift2, shift_mid;
    logic [2:0]  pos_mid;
    logic        done1, done2;

    // the whole back end moves together, held while the output waits
    assign adv     = !out_valid_reg || m_tready;
    assign cmd_pop = adv && cmd_valid;

    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            if (cmd.kind == CMD_WRITE) begin
                palette[cmd.addr_a[IDX_W-1:0]] <= cmd.rgb;
            end else begin
                rd_a_reg <= palette[cmd.addr_a[IDX_W-1:0]];
                rd_b_reg <= palette[cmd.addr_b[IDX_W-1:0]];
            end
            s1_kind_reg <= cmd.kind;
            s1_ok_a_reg <= cmd.ok_a;
            s1_rgb_reg  <= cmd.rgb;
        end
    end

    always_comb begin
        col_b = rd_b_reg;
        unique case (s1_kind_reg)
            CMD_DIRECT: col_a = s1_rgb_reg;
            CMD_PAL8:   col_a = s1_ok_a_reg ? rd_a_reg : 24'd0;
            default:    col_a = rd_a_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_two_reg   <= (s1_kind_reg == CMD_PAL4);
            s2_bit_a_reg <= (gray_of(col_a) > threshold);
            s2_bit_b_reg <= (gray_of(col_b) > threshold);
        end
    end

    always_comb begin
        shift1    = shift_reg | (8'(s2_bit_a_reg) << pos_reg);
        done1     = (pos_reg == 3'd0);
        shift_mid = done1 ? 8'd0 : shift1;
        pos_mid   = done1 ? 3'd7 : 3'(pos_reg - 3'd1);
        shift2    = shift_mid | (8'(s2_bit_b_reg) << pos_mid);
        done2     = (pos_mid == 3'd0);

        pos_next       = pos_reg;
        shift_next     = shift_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (adv) begin
            out_valid_next = 1'b0;
            if (s2_valid_reg) begin
                if (s2_two_reg) begin
                    shift_next = done2 ? 8'd0 : shift2;
                    pos_next   = done2 ? 3'd7 : 3'(pos_mid - 3'd1);
                end else begin
                    shift_next = shift_mid;
                    pos_next   = pos_mid;
                end
                // a byte completes on the first or the second nibble, never both
                out_valid_next = done1 || (s2_two_reg && done2);
                out_data_next  = done1 ? shift1 : shift2;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            pos_reg       <= 3'd7;
            shift_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                s1_valid_reg <= cmd_valid && (cmd.kind != CMD_WRITE);
                s2_valid_reg <= s1_valid_reg;
            end
            pos_reg       <= pos_next;
            shift_reg     <= shift_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: design/palette_gray_threshold_packer.sv
// palette_gray_threshold_packer: pixels in, packed monochrome bytes out.
// input stream s_*: s_tuser is the item kind (0 palette load, 1 pixel data);
// s_tdata carries entry_number, blue, green, red, pixel_code from bit 0 up.
// a load writes one palette entry; a pixel item gives one pixel, or two
// pixels in four-bit mode, each thresholded on (76r+150g+30b)>>8.
// output stream m_*: one byte per eight pixels, first pixel in bit 7;
// partial bytes are held across lines and never flushed.
// cfg_we/cfg_addr/cfg_wdata write pixel_mode (0) and gray_threshold (1); the user
// must write them only while the stream is idle, which the block does not enforce.
// throughput: one item per cycle while s_tready is high; a byte shows on m_tdata
// after the item that completes it passes the queue, palette read, gray, pack.
// the palette is a two-read-port memory, so two nibble lookups fit a cycle.
// reset: mode 8-bit, threshold 200, packer empty; palette holds nothing
// valid until loaded.
// when m_tready is low the back end holds, a 4-item queue absorbs input,
// then s_tready drops; no item is lost.
module palette_gray_threshold_packer #(
    parameter int PALETTE_DEPTH = pgtp_pkg::PALETTE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // entry_number, blue, green, red, pixel_code
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // packed_byte
);
    import pgtp_pkg::*;

    logic       q_full;
    logic       q_push;
    cmd_t       q_cmd;
    logic       q_pop;
    logic       q_not_empty;
    cmd_t       q_head;
    logic [7:0] threshold;

    pgtp_front #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd),
        .threshold(threshold)
    );

    pgtp_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .not_empty(q_not_empty),
        .head_cmd (q_head)
    );

    pgtp_back #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_valid(q_not_empty),
        .cmd      (q_head),
        .cmd_pop  (q_pop),
        .threshold(threshold),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
